[hw/rtl/lavm_pkg.sv]
// shared fixed-point types and command codes for the look-at view matrix unit
package lavm_pkg;

    typedef logic signed [31:0] t_s32;
    typedef logic signed [63:0] t_c64;

    localparam logic CMD_TARGET  = 1'b0;
    localparam logic CMD_REORTHO = 1'b1;

endpackage

[hw/rtl/lavm_norm.sv]
// pipelined vector normalizer: scale, sum of squares, square root, divide
module lavm_norm #(
    parameter int SW = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  lavm_pkg::t_c64      i_c [3],
    input  logic [SW-1:0]       i_side,
    output logic                o_valid,
    output lavm_pkg::t_s32      o_u [3],
    output logic [SW-1:0]       o_side
);

    localparam int SQ_N = 32;
    localparam int DV_N = 31;
    localparam int LAT  = SQ_N + DV_N + 7;

    typedef struct packed {
        logic [63:0]       s;
        logic [34:0]       rem;
        logic [31:0]       q;
        logic [2:0][30:0]  mg;
        logic [2:0]        sgn;
        logic              zero;
    } t_sq;

    typedef struct packed {
        logic [31:0]       n;
        logic [2:0][31:0]  rem;
        logic [2:0][30:0]  lo;
        logic [2:0][30:0]  q;
        logic [2:0]        sgn;
        logic              zero;
    } t_dv;

    function automatic t_sq sq_step(input t_sq a);
        t_sq         r;
        logic [34:0] rem2;
        logic [34:0] trial;
        r     = a;
        rem2  = {a.rem[32:0], a.s[63:62]};
        trial = {1'b0, a.q, 2'b01};
        r.s   = {a.s[61:0], 2'b00};
        if (rem2 >= trial) begin
            r.rem = rem2 - trial;
            r.q   = {a.q[30:0], 1'b1};
        end else begin
            r.rem = rem2;
            r.q   = {a.q[30:0], 1'b0};
        end
        return r;
    endfunction

    function automatic t_dv dv_step(input t_dv a);
        t_dv         r;
        logic [32:0] r2;
        logic        qb;
        r = a;
        for (int i = 0; i < 3; i++) begin
            r2 = {a.rem[i], a.lo[i][30]};
            if (r2 >= {1'b0, a.n}) begin
                r.rem[i] = 32'(r2 - {1'b0, a.n});
                qb       = 1'b1;
            end else begin
                r.rem[i] = r2[31:0];
                qb       = 1'b0;
            end
            r.lo[i] = {a.lo[i][29:0], 1'b0};
            r.q[i]  = {a.q[i][29:0], qb};
        end
        return r;
    endfunction

    logic [2:0][63:0] n1_mag;
    logic [2:0][63:0] r1_mag;
    logic [2:0]       r1_sgn;
    logic [6:0]       n2_bl;
    logic [6:0]       r2_bl;
    logic [2:0][63:0] r2_mag;
    logic [2:0]       r2_sgn;
    logic [2:0][30:0] n3_mg;
    logic [2:0][30:0] r3_mg;
    logic [2:0]       r3_sgn;
    logic             r3_zero;
    logic [2:0][61:0] r4_sq;
    logic [2:0][30:0] r4_mg;
    logic [2:0]       r4_sgn;
    logic             r4_zero;
    logic [63:0]      r5_s;
    logic [2:0][30:0] r5_mg;
    logic [2:0]       r5_sgn;
    logic             r5_zero;
    t_sq              sq_in [SQ_N];
    t_sq              r_sq  [SQ_N];
    t_dv              n_d0;
    t_dv              r_d0;
    t_dv              dv_in [DV_N];
    t_dv              r_dv  [DV_N];
    lavm_pkg::t_s32   n_u [3];
    lavm_pkg::t_s32   r_u [3];
    logic             r_vld [LAT];
    logic [SW-1:0]    r_sd  [LAT];

    always_comb begin
        logic [63:0] orv;
        logic [94:0] wide;
        logic [61:0] num;
        logic [31:0] mag32;
        orv = '0;
        for (int i = 0; i < 3; i++) begin
            n1_mag[i] = i_c[i][63] ? (~i_c[i] + 64'd1) : i_c[i];
            orv       = orv | r1_mag[i];
        end
        n2_bl = '0;
        for (int b = 0; b < 64; b++) begin
            if (orv[b]) begin
                n2_bl = 7'(b + 1);
            end
        end
        for (int i = 0; i < 3; i++) begin
            wide     = {r2_mag[i], 31'd0} >> r2_bl;
            n3_mg[i] = wide[30:0];
        end
        sq_in[0].s    = r5_s;
        sq_in[0].rem  = '0;
        sq_in[0].q    = '0;
        sq_in[0].mg   = r5_mg;
        sq_in[0].sgn  = r5_sgn;
        sq_in[0].zero = r5_zero;
        for (int k = 1; k < SQ_N; k++) begin
            sq_in[k] = r_sq[k-1];
        end
        n_d0.n    = r_sq[SQ_N-1].q;
        n_d0.sgn  = r_sq[SQ_N-1].sgn;
        n_d0.zero = r_sq[SQ_N-1].zero;
        n_d0.q    = '0;
        for (int i = 0; i < 3; i++) begin
            num = 62'({r_sq[SQ_N-1].mg[i], 30'd0}) + 62'(r_sq[SQ_N-1].q[31:1]);
            n_d0.rem[i] = 32'(num[61:31]);
            n_d0.lo[i]  = num[30:0];
        end
        dv_in[0] = r_d0;
        for (int k = 1; k < DV_N; k++) begin
            dv_in[k] = r_dv[k-1];
        end
        for (int i = 0; i < 3; i++) begin
            mag32 = {1'b0, r_dv[DV_N-1].q[i]};
            if (r_dv[DV_N-1].zero) begin
                n_u[i] = '0;
            end else if (r_dv[DV_N-1].sgn[i]) begin
                n_u[i] = lavm_pkg::t_s32'(-mag32);
            end else begin
                n_u[i] = lavm_pkg::t_s32'(mag32);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_mag  <= n1_mag;
            for (int i = 0; i < 3; i++) begin
                r1_sgn[i] <= i_c[i][63];
                r4_sq[i]  <= r3_mg[i] * r3_mg[i];
            end
            r2_bl   <= n2_bl;
            r2_mag  <= r1_mag;
            r2_sgn  <= r1_sgn;
            r3_mg   <= n3_mg;
            r3_sgn  <= r2_sgn;
            r3_zero <= (r2_bl == '0);
            r4_mg   <= r3_mg;
            r4_sgn  <= r3_sgn;
            r4_zero <= r3_zero;
            r5_s    <= 64'(r4_sq[0]) + 64'(r4_sq[1]) + 64'(r4_sq[2]);
            r5_mg   <= r4_mg;
            r5_sgn  <= r4_sgn;
            r5_zero <= r4_zero;
            for (int k = 0; k < SQ_N; k++) begin
                r_sq[k] <= sq_step(sq_in[k]);
            end
            r_d0 <= n_d0;
            for (int k = 0; k < DV_N; k++) begin
                r_dv[k] <= dv_step(dv_in[k]);
            end
            r_u <= n_u;
            r_sd[0] <= i_side;
            for (int k = 1; k < LAT; k++) begin
                r_sd[k] <= r_sd[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < LAT; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (i_en) begin
            r_vld[0] <= i_valid;
            for (int k = 1; k < LAT; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    assign o_valid = r_vld[LAT-1];
    assign o_u     = r_u;
    assign o_side  = r_sd[LAT-1];

endmodule

[hw/rtl/look_at_view_matrix_unit.sv]
// look-at view matrix unit: rotation rows and translation of a camera view matrix
// One beat enters per cycle while the output is not stalled and passes eight
// stages of input, cross product, dot product and saturation registers, plus
// three normalizers of 70 stages each (range scaling, squares, a 32-stage
// square root and a 31-stage divider). A stall on the output holds the whole
// pipeline; o_in_ready is high whenever the output register is empty or being
// taken. Right, up and look are Q2.30, translations are Q16.16 saturated.
module look_at_view_matrix_unit (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic                  i_command,
    input  logic signed [31:0]    i_pos_x,
    input  logic signed [31:0]    i_pos_y,
    input  logic signed [31:0]    i_pos_z,
    input  logic signed [31:0]    i_vec_a_x,
    input  logic signed [31:0]    i_vec_a_y,
    input  logic signed [31:0]    i_vec_a_z,
    input  logic signed [31:0]    i_vec_b_x,
    input  logic signed [31:0]    i_vec_b_y,
    input  logic signed [31:0]    i_vec_b_z,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic signed [31:0]    o_right_x,
    output logic signed [31:0]    o_right_y,
    output logic signed [31:0]    o_right_z,
    output logic signed [31:0]    o_up_x,
    output logic signed [31:0]    o_up_y,
    output logic signed [31:0]    o_up_z,
    output logic signed [31:0]    o_look_x,
    output logic signed [31:0]    o_look_y,
    output logic signed [31:0]    o_look_z,
    output logic signed [31:0]    o_trans_x,
    output logic signed [31:0]    o_trans_y,
    output logic signed [31:0]    o_trans_z
);

    typedef logic signed [65:0] t_acc;
    localparam t_acc HALF_Q30 = 66'sd536870912;
    localparam lavm_pkg::t_s32 SAT_MAX = 32'sh7fffffff;
    localparam lavm_pkg::t_s32 SAT_MIN = 32'sh80000000;

    typedef struct packed {
        logic                       cmd;
        lavm_pkg::t_s32 [2:0]       p;
        lavm_pkg::t_s32 [2:0]       b;
    } t_side_look;

    typedef struct packed {
        lavm_pkg::t_s32 [2:0]       p;
        lavm_pkg::t_s32 [2:0]       look;
    } t_side_up;

    typedef struct packed {
        lavm_pkg::t_s32 [2:0]       p;
        lavm_pkg::t_s32 [2:0]       look;
        lavm_pkg::t_s32 [2:0]       up;
    } t_side_right;

    function automatic lavm_pkg::t_c64 mul32(input lavm_pkg::t_s32 a, input lavm_pkg::t_s32 b);
        return lavm_pkg::t_c64'(a) * lavm_pkg::t_c64'(b);
    endfunction

    logic            w_en;
    lavm_pkg::t_s32  w_p [3];
    lavm_pkg::t_s32  w_a [3];
    lavm_pkg::t_s32  w_b [3];

    logic            r0_v;
    logic            r0_cmd;
    lavm_pkg::t_s32  r0_p [3];
    lavm_pkg::t_s32  r0_b [3];
    lavm_pkg::t_c64  r0_c [3];

    t_side_look      w_sl_in;
    t_side_look      w_sl_out;
    logic            w_look_v;
    lavm_pkg::t_s32  w_look [3];

    logic            r1_v;
    logic            r1_cmd;
    lavm_pkg::t_s32  r1_p [3];
    lavm_pkg::t_s32  r1_b [3];
    lavm_pkg::t_s32  r1_look [3];
    lavm_pkg::t_c64  r1_pr [6];

    logic            r2_v;
    lavm_pkg::t_c64  n2_c [3];
    lavm_pkg::t_c64  r2_c [3];
    lavm_pkg::t_s32  r2_p [3];
    lavm_pkg::t_s32  r2_look [3];

    t_side_up        w_su_in;
    t_side_up        w_su_out;
    logic            w_up_v;
    lavm_pkg::t_s32  w_up [3];

    logic            r3_v;
    lavm_pkg::t_s32  r3_p [3];
    lavm_pkg::t_s32  r3_look [3];
    lavm_pkg::t_s32  r3_up [3];
    lavm_pkg::t_c64  r3_pr [6];

    logic            r4_v;
    lavm_pkg::t_c64  r4_c [3];
    lavm_pkg::t_s32  r4_p [3];
    lavm_pkg::t_s32  r4_look [3];
    lavm_pkg::t_s32  r4_up [3];

    t_side_right     w_sr_in;
    t_side_right     w_sr_out;
    logic            w_right_v;
    lavm_pkg::t_s32  w_right [3];

    logic            r5_v;
    lavm_pkg::t_c64  r5_pr [3][3];
    lavm_pkg::t_s32  r5_vec [3][3];

    logic            r6_v;
    t_acc            r6_x [3];
    lavm_pkg::t_s32  r6_vec [3][3];

    logic            r7_v;
    lavm_pkg::t_s32  n7_t [3];
    lavm_pkg::t_s32  r7_t [3];
    lavm_pkg::t_s32  r7_vec [3][3];

    assign w_en       = !r7_v || i_out_ready;
    assign o_in_ready = w_en;

    assign w_p = '{i_pos_x, i_pos_y, i_pos_z};
    assign w_a = '{i_vec_a_x, i_vec_a_y, i_vec_a_z};
    assign w_b = '{i_vec_b_x, i_vec_b_y, i_vec_b_z};

    always_comb begin
        w_sl_in.cmd = r0_cmd;
        for (int i = 0; i < 3; i++) begin
            w_sl_in.p[i]   = r0_p[i];
            w_sl_in.b[i]   = r0_b[i];
            w_su_in.p[i]   = r2_p[i];
            w_su_in.look[i] = r2_look[i];
            w_sr_in.p[i]   = r4_p[i];
            w_sr_in.look[i] = r4_look[i];
            w_sr_in.up[i]  = r4_up[i];
        end
        if (r1_cmd == lavm_pkg::CMD_REORTHO) begin
            n2_c[0] = r1_pr[0] - r1_pr[1];
            n2_c[1] = r1_pr[2] - r1_pr[3];
            n2_c[2] = r1_pr[4] - r1_pr[5];
        end else begin
            for (int i = 0; i < 3; i++) begin
                n2_c[i] = lavm_pkg::t_c64'(r1_b[i]);
            end
        end
    end

    lavm_norm #(.SW($bits(t_side_look))) u_norm_look (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r0_v),
        .i_c     (r0_c),
        .i_side  (w_sl_in),
        .o_valid (w_look_v),
        .o_u     (w_look),
        .o_side  (w_sl_out)
    );

    lavm_norm #(.SW($bits(t_side_up))) u_norm_up (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r2_v),
        .i_c     (r2_c),
        .i_side  (w_su_in),
        .o_valid (w_up_v),
        .o_u     (w_up),
        .o_side  (w_su_out)
    );

    lavm_norm #(.SW($bits(t_side_right))) u_norm_right (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r4_v),
        .i_c     (r4_c),
        .i_side  (w_sr_in),
        .o_valid (w_right_v),
        .o_u     (w_right),
        .o_side  (w_sr_out)
    );

    always_comb begin
        t_acc sh;
        for (int v = 0; v < 3; v++) begin
            sh = r6_x[v] >>> 30;
            if (sh[65:31] == '0 || sh[65:31] == '1) begin
                n7_t[v] = sh[31:0];
            end else if (sh[65]) begin
                n7_t[v] = SAT_MIN;
            end else begin
                n7_t[v] = SAT_MAX;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r0_cmd <= i_command;
            for (int i = 0; i < 3; i++) begin
                r0_p[i] <= w_p[i];
                r0_b[i] <= w_b[i];
                if (i_command == lavm_pkg::CMD_REORTHO) begin
                    r0_c[i] <= lavm_pkg::t_c64'(w_a[i]);
                end else begin
                    r0_c[i] <= lavm_pkg::t_c64'(w_a[i]) - lavm_pkg::t_c64'(w_p[i]);
                end
            end

            r1_cmd <= w_sl_out.cmd;
            for (int i = 0; i < 3; i++) begin
                r1_p[i]    <= w_sl_out.p[i];
                r1_b[i]    <= w_sl_out.b[i];
                r1_look[i] <= w_look[i];
            end
            r1_pr[0] <= mul32(w_look[1], w_sl_out.b[2]);
            r1_pr[1] <= mul32(w_look[2], w_sl_out.b[1]);
            r1_pr[2] <= mul32(w_look[2], w_sl_out.b[0]);
            r1_pr[3] <= mul32(w_look[0], w_sl_out.b[2]);
            r1_pr[4] <= mul32(w_look[0], w_sl_out.b[1]);
            r1_pr[5] <= mul32(w_look[1], w_sl_out.b[0]);

            r2_c    <= n2_c;
            r2_p    <= r1_p;
            r2_look <= r1_look;

            for (int i = 0; i < 3; i++) begin
                r3_p[i]    <= w_su_out.p[i];
                r3_look[i] <= w_su_out.look[i];
                r3_up[i]   <= w_up[i];
            end
            r3_pr[0] <= mul32(w_up[1], w_su_out.look[2]);
            r3_pr[1] <= mul32(w_up[2], w_su_out.look[1]);
            r3_pr[2] <= mul32(w_up[2], w_su_out.look[0]);
            r3_pr[3] <= mul32(w_up[0], w_su_out.look[2]);
            r3_pr[4] <= mul32(w_up[0], w_su_out.look[1]);
            r3_pr[5] <= mul32(w_up[1], w_su_out.look[0]);

            r4_c[0] <= r3_pr[0] - r3_pr[1];
            r4_c[1] <= r3_pr[2] - r3_pr[3];
            r4_c[2] <= r3_pr[4] - r3_pr[5];
            r4_p    <= r3_p;
            r4_look <= r3_look;
            r4_up   <= r3_up;

            for (int i = 0; i < 3; i++) begin
                r5_vec[0][i] <= w_right[i];
                r5_vec[1][i] <= w_sr_out.up[i];
                r5_vec[2][i] <= w_sr_out.look[i];
                r5_pr[0][i]  <= mul32(w_sr_out.p[i], w_right[i]);
                r5_pr[1][i]  <= mul32(w_sr_out.p[i], w_sr_out.up[i]);
                r5_pr[2][i]  <= mul32(w_sr_out.p[i], w_sr_out.look[i]);
            end

            for (int v = 0; v < 3; v++) begin
                r6_x[v] <= HALF_Q30 - (t_acc'(r5_pr[v][0]) + t_acc'(r5_pr[v][1])
                                       + t_acc'(r5_pr[v][2]));
            end
            r6_vec <= r5_vec;

            r7_t   <= n7_t;
            r7_vec <= r6_vec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_v <= 1'b0;
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
            r5_v <= 1'b0;
            r6_v <= 1'b0;
            r7_v <= 1'b0;
        end else if (w_en) begin
            r0_v <= i_in_valid;
            r1_v <= w_look_v;
            r2_v <= r1_v;
            r3_v <= w_up_v;
            r4_v <= r3_v;
            r5_v <= w_right_v;
            r6_v <= r5_v;
            r7_v <= r6_v;
        end
    end

    assign o_out_valid = r7_v;
    assign o_right_x   = r7_vec[0][0];
    assign o_right_y   = r7_vec[0][1];
    assign o_right_z   = r7_vec[0][2];
    assign o_up_x      = r7_vec[1][0];
    assign o_up_y      = r7_vec[1][1];
    assign o_up_z      = r7_vec[1][2];
    assign o_look_x    = r7_vec[2][0];
    assign o_look_y    = r7_vec[2][1];
    assign o_look_z    = r7_vec[2][2];
    assign o_trans_x   = r7_t[0];
    assign o_trans_y   = r7_t[1];
    assign o_trans_z   = r7_t[2];

endmodule

[hw/rtl/lavm_chk.sv]
// port checker for the look-at view matrix unit, bound to the top level
module lavm_chk (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  o_in_ready,
    input logic                  o_out_valid,
    input logic                  i_out_ready,
    input logic signed [31:0]    o_right_x,
    input logic signed [31:0]    o_right_z,
    input logic signed [31:0]    o_up_y,
    input logic signed [31:0]    o_look_x,
    input logic signed [31:0]    o_look_z,
    input logic signed [31:0]    o_trans_x
);

    localparam logic signed [31:0] UNIT_MAX = 32'sh40000000;
    localparam logic signed [31:0] UNIT_MIN = -32'sh40000000;

    // output beat held while stalled
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("output beat dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_trans_x) && $stable(o_right_x)
            && $stable(o_look_z))
        else $error("output beat changed while stalled");

    // empty output means the pipe can advance
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with empty output");

    a_ready_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |-> !o_in_ready)
        else $error("input taken while output stalled");

    a_unit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_look_x <= UNIT_MAX && o_look_x >= UNIT_MIN
            && o_up_y <= UNIT_MAX && o_up_y >= UNIT_MIN
            && o_right_z <= UNIT_MAX && o_right_z >= UNIT_MIN)
        else $error("unit vector component out of range");

endmodule

bind look_at_view_matrix_unit lavm_chk u_lavm_chk (.*);
